// ===== hdl/assert_macros.svh =====
// Assertion macros shared by the block's RTL.
// Define NO_ASSERTIONS to compile every check away.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
`define ASSERT_SYNC(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);
`define ASSERT_NEXT(label, clk, rst, pre, post, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);
`else
`define ASSERT_SYNC(label, clk, rst, prop, msg)
`define ASSERT_NEXT(label, clk, rst, pre, post, msg)
`endif
`endif

// ===== hdl/blgq_pkg.sv =====
// ----------------------------------------------------------------------------
// blgq_pkg
// Item types, register codes, controller states and the command and status
// groups that join the controller to the datapath.
// ----------------------------------------------------------------------------
package blgq_pkg;

  typedef struct packed {
    logic       cmd;
    logic       frame_start;
    logic [7:0] pixel_red;
    logic [7:0] pixel_green;
    logic [7:0] pixel_blue;
  } in_item_t;

  typedef struct packed {
    logic [5:0] glyph_index;
    logic [7:0] mean_red;
    logic [7:0] mean_green;
    logic [7:0] mean_blue;
    logic [8:0] cell_column;
    logic [7:0] cell_row;
    logic       last_cell;
    logic       cell_valid;
  } out_item_t;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 9;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_BLOCK_SIZE,
    REG_GLYPH_COUNT,
    REG_INVERT_ORDER,
    REG_COLOUR_MODE,
    REG_IMAGE_WIDTH,
    REG_IMAGE_HEIGHT
  } cfg_reg_t;

  localparam logic [5:0] RST_BLOCK_SIZE   = 6'd8;
  localparam logic [6:0] RST_GLYPH_COUNT  = 7'd10;
  localparam logic       RST_INVERT_ORDER = 1'b0;
  localparam logic       RST_COLOUR_MODE  = 1'b0;
  localparam logic [8:0] RST_IMAGE_WIDTH  = 9'd320;
  localparam logic [7:0] RST_IMAGE_HEIGHT = 8'd240;

  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_CELL = 1'b1;

  // Luma weights in 16-bit fixed point; they sum slightly above one.
  localparam logic [15:0] LUMA_WR  = 16'd13933;
  localparam logic [15:0] LUMA_WG  = 16'd46871;
  localparam logic [15:0] LUMA_WB  = 16'd7471;
  localparam logic [7:0]  LUMA_TOP = 8'd255;

  // Multiplying by 683 and shifting right by 11 divides by three exactly for
  // every sum below 2048, which covers three 8-bit means.
  localparam logic [9:0] AVG_RECIP = 10'd683;
  localparam int         AVG_SHIFT = 11;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_LOAD,
    ST_COLS,
    ST_ROWS,
    ST_CLAMP,
    ST_SETUP,
    ST_BOUNDS,
    ST_BASE,
    ST_SCAN,
    ST_DRAIN,
    ST_DIV_R,
    ST_DIV_G,
    ST_DIV_B,
    ST_AVG,
    ST_DIV_IDX,
    ST_FINISH
  } state_t;

  typedef enum logic [2:0] {
    DIV_COLS,
    DIV_ROWS,
    DIV_RED,
    DIV_GREEN,
    DIV_BLUE,
    DIV_IDX
  } div_sel_t;

  typedef struct packed {
    logic     restart;
    logic     load;
    logic     clamp;
    logic     setup;
    logic     bounds;
    logic     base;
    logic     scan;
    logic     average;
    logic     div_start;
    div_sel_t div_sel;
    logic     finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic empty_grid;
    logic scan_last;
    logic div_done;
    logic out_free;
    logic colour_mode;
  } ctrl_status_t;

endpackage

// ===== hdl/blgq_ram.sv =====
// ----------------------------------------------------------------------------
// blgq_ram
// Generic simple dual-port RAM: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module blgq_ram #(
  parameter int WIDTH = 24,
  parameter int DEPTH = 76800
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== hdl/blgq_div.sv =====
// ----------------------------------------------------------------------------
// blgq_div
// Restoring unsigned divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
module blgq_div #(
  parameter int W = 20
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         start,
  input  logic [W-1:0] num,
  input  logic [W-1:0] den,
  output logic         done,
  output logic [W-1:0] quo
);

  localparam int CW = $clog2(W);

  logic [W:0]    rem;
  logic [W-1:0]  den_r;
  logic [CW-1:0] count;
  logic          busy;
  logic [W:0]    rem_sh;
  logic [W+1:0]  trial;

  assign rem_sh = {rem[W-1:0], quo[W-1]};
  assign trial  = {1'b0, rem_sh} - {2'b00, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && count == '0) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem   <= '0;
      quo   <= num;
      den_r <= den;
      count <= CW'(W - 1);
    end else if (busy) begin
      count <= count - CW'(1);
      if (!trial[W+1]) begin
        rem <= trial[W:0];
        quo <= {quo[W-2:0], 1'b1};
      end else begin
        rem <= rem_sh;
        quo <= {quo[W-2:0], 1'b0};
      end
    end
  end

endmodule

// ===== hdl/blgq_ctrl.sv =====
// ----------------------------------------------------------------------------
// blgq_ctrl
// Sequencer: steps the datapath through a pixel load or a cell computation.
// ----------------------------------------------------------------------------
module blgq_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_cmd,
  output logic                   in_ready,
  output blgq_pkg::ctrl_cmd_t    cmd,
  input  blgq_pkg::ctrl_status_t status
);
  import blgq_pkg::*;

  state_t state, state_next;
  logic   launched;
  logic   div_state;

  assign div_state = state inside {ST_COLS, ST_ROWS, ST_DIV_R, ST_DIV_G, ST_DIV_B,
                                   ST_DIV_IDX};

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      launched <= 1'b0;
    end else begin
      state <= state_next;
      if (status.div_done) begin
        launched <= 1'b0;
      end else if (cmd.div_start) begin
        launched <= 1'b1;
      end
    end
  end

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          state_next = (in_cmd == CMD_LOAD) ? ST_LOAD : ST_COLS;
        end
      end
      ST_LOAD:    state_next = ST_IDLE;
      ST_COLS:    if (status.div_done) state_next = ST_ROWS;
      ST_ROWS:    if (status.div_done) state_next = ST_CLAMP;
      ST_CLAMP:   state_next = status.empty_grid ? ST_FINISH : ST_SETUP;
      ST_SETUP:   state_next = ST_BOUNDS;
      ST_BOUNDS:  state_next = ST_BASE;
      ST_BASE:    state_next = ST_SCAN;
      ST_SCAN:    if (status.scan_last) state_next = ST_DRAIN;
      ST_DRAIN:   state_next = ST_DIV_R;
      ST_DIV_R: begin
        if (status.div_done) begin
          state_next = status.colour_mode ? ST_DIV_G : ST_AVG;
        end
      end
      ST_DIV_G:   if (status.div_done) state_next = ST_DIV_B;
      ST_DIV_B:   if (status.div_done) state_next = ST_AVG;
      ST_AVG:     state_next = ST_DIV_IDX;
      ST_DIV_IDX: if (status.div_done) state_next = ST_FINISH;
      ST_FINISH:  if (status.out_free) state_next = ST_IDLE;
      default:    state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    cmd           = '0;
    in_ready      = 1'b0;
    cmd.div_start = div_state && !launched;
    case (state)
      ST_IDLE:    in_ready = 1'b1;
      ST_LOAD: begin
        cmd.restart = 1'b1;
        cmd.load    = 1'b1;
      end
      ST_COLS: begin
        cmd.restart = 1'b1;
        cmd.div_sel = DIV_COLS;
      end
      ST_ROWS:    cmd.div_sel = DIV_ROWS;
      ST_CLAMP:   cmd.clamp = 1'b1;
      ST_SETUP:   cmd.setup = 1'b1;
      ST_BOUNDS:  cmd.bounds = 1'b1;
      ST_BASE:    cmd.base = 1'b1;
      ST_SCAN:    cmd.scan = 1'b1;
      ST_DIV_R:   cmd.div_sel = DIV_RED;
      ST_DIV_G:   cmd.div_sel = DIV_GREEN;
      ST_DIV_B:   cmd.div_sel = DIV_BLUE;
      ST_AVG:     cmd.average = 1'b1;
      ST_DIV_IDX: cmd.div_sel = DIV_IDX;
      ST_FINISH:  cmd.finish = 1'b1;
      default:    cmd = '0;
    endcase
  end

endmodule

// ===== hdl/blgq_dp.sv =====
// ----------------------------------------------------------------------------
// blgq_dp
// Datapath: configuration registers, pixel store, luma tracking, window
// accumulation, shared divider and the output register.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module blgq_dp #(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240,
  parameter int MAX_BLOCK  = 32,
  parameter int MAX_GLYPHS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_accept,
  input  blgq_pkg::in_item_t               in_item,
  input  logic                             cfg_write,
  input  logic [blgq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blgq_pkg::CFG_DATA_W-1:0]  cfg_data,
  input  logic                             out_ready,
  output logic                             out_valid,
  output blgq_pkg::out_item_t              out_item,
  input  blgq_pkg::ctrl_cmd_t              cmd,
  output blgq_pkg::ctrl_status_t           status
);
  import blgq_pkg::*;

  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(DEPTH);
  localparam int WAW   = $clog2(DEPTH + 1);
  localparam int XW    = $clog2(MAX_WIDTH + 1);
  localparam int YW    = $clog2(MAX_HEIGHT + 1);
  localparam int BW    = $clog2(MAX_BLOCK + 1);
  localparam int GW    = $clog2(MAX_GLYPHS + 1);
  localparam int XT    = (XW > BW ? XW : BW) + 1;
  localparam int YT    = (YW > BW ? YW : BW) + 1;
  localparam int CNT_W = $clog2(4 * MAX_BLOCK * MAX_BLOCK + 1);
  localparam int SUM_W = $clog2(4 * MAX_BLOCK * MAX_BLOCK * 255 + 1);
  localparam int DIV_W = SUM_W > 16 ? SUM_W : 16;

  // Configuration registers.
  logic [5:0] block_size;
  logic [6:0] glyph_count;
  logic       invert_order;
  logic       colour_mode;
  logic [8:0] image_width;
  logic [7:0] image_height;

  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [BW-1:0] b_eff;
  logic [GW-1:0] g_eff;
  logic [WAW-1:0] frame_pixels;

  in_item_t item;

  logic [WAW-1:0] wa, wa_eff;
  logic [7:0]     lmin, lmax, min_eff, max_eff;
  logic [24:0]    luma_acc;
  logic [7:0]     luma;
  logic           restart_now;
  logic           store_ok;

  logic [XW-1:0] col, cols, x0, istart, iend, i;
  logic [YW-1:0] row, rows, y0, jstart, jend, j;
  logic [AW-1:0] row_base, rd_addr;
  logic [23:0]   rd_data, wr_data;
  logic          rd_pend;
  logic [SUM_W-1:0] sr, sg, sb;
  logic [CNT_W-1:0] cnt;
  logic          empty;
  logic          scan_last;

  logic [7:0]    mr, mg, mb, avg;
  logic [9:0]    avg_sum;
  logic [19:0]   avg_prod;
  logic [15:0]   idx_raw;
  logic [GW-1:0] gm1, glyph, glyph_sel;

  logic [DIV_W-1:0] div_num, div_den, div_quo;
  logic             div_done;
  logic             out_free;

  logic [XT-1:0] xs, bx, wx;
  logic [YT-1:0] ys, by, hy;

  // Out-of-range register values saturate to the legal range.
  always_comb begin
    if (image_width == '0) w_eff = XW'(1);
    else if (32'(image_width) > MAX_WIDTH) w_eff = XW'(MAX_WIDTH);
    else w_eff = XW'(image_width);
    if (image_height == '0) h_eff = YW'(1);
    else if (32'(image_height) > MAX_HEIGHT) h_eff = YW'(MAX_HEIGHT);
    else h_eff = YW'(image_height);
    if (block_size == '0) b_eff = BW'(1);
    else if (32'(block_size) > MAX_BLOCK) b_eff = BW'(MAX_BLOCK);
    else b_eff = BW'(block_size);
    if (glyph_count == '0) g_eff = GW'(1);
    else if (32'(glyph_count) > MAX_GLYPHS) g_eff = GW'(MAX_GLYPHS);
    else g_eff = GW'(glyph_count);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      block_size   <= RST_BLOCK_SIZE;
      glyph_count  <= RST_GLYPH_COUNT;
      invert_order <= RST_INVERT_ORDER;
      colour_mode  <= RST_COLOUR_MODE;
      image_width  <= RST_IMAGE_WIDTH;
      image_height <= RST_IMAGE_HEIGHT;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_BLOCK_SIZE:   block_size   <= cfg_data[5:0];
        REG_GLYPH_COUNT:  glyph_count  <= cfg_data[6:0];
        REG_INVERT_ORDER: invert_order <= cfg_data[0];
        REG_COLOUR_MODE:  colour_mode  <= cfg_data[0];
        REG_IMAGE_WIDTH:  image_width  <= cfg_data[8:0];
        REG_IMAGE_HEIGHT: image_height <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    frame_pixels <= WAW'(w_eff) * WAW'(h_eff);
    if (in_accept) begin
      item <= in_item;
    end
  end

  // Pixel load. A frame start clears the address and the luma bounds first.
  assign restart_now = cmd.restart && item.frame_start;
  assign wa_eff      = restart_now ? '0 : wa;
  assign min_eff     = restart_now ? LUMA_TOP : lmin;
  assign max_eff     = restart_now ? '0 : lmax;
  assign luma_acc    = 25'(LUMA_WR) * 25'(item.pixel_red)
                     + 25'(LUMA_WG) * 25'(item.pixel_green)
                     + 25'(LUMA_WB) * 25'(item.pixel_blue);
  assign luma        = luma_acc[24] ? LUMA_TOP : luma_acc[23:16];
  assign store_ok    = wa_eff < frame_pixels;
  assign wr_data     = colour_mode ? {item.pixel_red, item.pixel_green, item.pixel_blue}
                                   : {luma, luma, luma};

  always_ff @(posedge clk) begin
    if (rst) begin
      wa   <= '0;
      lmin <= LUMA_TOP;
      lmax <= '0;
    end else if (cmd.load) begin
      if (store_ok) begin
        wa   <= wa_eff + WAW'(1);
        lmin <= (luma < min_eff) ? luma : min_eff;
        lmax <= (luma > max_eff) ? luma : max_eff;
      end else begin
        wa   <= wa_eff;
        lmin <= min_eff;
        lmax <= max_eff;
      end
    end else if (restart_now) begin
      wa   <= '0;
      lmin <= LUMA_TOP;
      lmax <= '0;
    end
  end

  blgq_ram #(
    .WIDTH(24),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (cmd.load && store_ok),
    .waddr(wa_eff[AW-1:0]),
    .wdata(wr_data),
    .raddr(rd_addr),
    .rdata(rd_data)
  );

  // Cell cursor.
  assign empty    = (cols == '0) || (rows == '0);
  assign out_free = !out_valid || out_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      col <= '0;
      row <= '0;
    end else if (restart_now) begin
      col <= '0;
      row <= '0;
    end else if (cmd.clamp && !empty) begin
      if (col >= cols) col <= '0;
      if (row >= rows) row <= '0;
    end else if (cmd.finish && out_free && !empty) begin
      if (col == cols - XW'(1)) begin
        col <= '0;
        row <= (row == rows - YW'(1)) ? '0 : row + YW'(1);
      end else begin
        col <= col + XW'(1);
      end
    end
  end

  // Window bounds, clipped to the image.
  assign xs = XT'(x0);
  assign bx = XT'(b_eff);
  assign wx = XT'(w_eff);
  assign ys = YT'(y0);
  assign by = YT'(b_eff);
  assign hy = YT'(h_eff);

  assign rd_addr   = row_base + AW'(i);
  assign scan_last = (i == iend - XW'(1)) && (j == jend - YW'(1));

  always_ff @(posedge clk) begin
    if (cmd.setup) begin
      x0 <= XW'((XW+BW)'(col) * (XW+BW)'(b_eff));
      y0 <= YW'((YW+BW)'(row) * (YW+BW)'(b_eff));
    end
    if (cmd.bounds) begin
      istart <= (xs >= bx) ? XW'(xs - bx) : '0;
      iend   <= (xs + bx > wx) ? w_eff : XW'(xs + bx);
      jstart <= (ys >= by) ? YW'(ys - by) : '0;
      jend   <= (ys + by > hy) ? h_eff : YW'(ys + by);
    end
    if (cmd.base) begin
      row_base <= AW'(AW'(jstart) * AW'(w_eff));
      i        <= istart;
      j        <= jstart;
    end else if (cmd.scan) begin
      if (i == iend - XW'(1)) begin
        i        <= istart;
        j        <= j + YW'(1);
        row_base <= row_base + AW'(w_eff);
      end else begin
        i <= i + XW'(1);
      end
    end
  end

  // Read data arrives in the cycle after its address.
  always_ff @(posedge clk) begin
    if (rst) begin
      rd_pend <= 1'b0;
    end else begin
      rd_pend <= cmd.scan;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.base) begin
      sr  <= '0;
      sg  <= '0;
      sb  <= '0;
      cnt <= '0;
    end else if (rd_pend) begin
      sr  <= sr + SUM_W'(rd_data[23:16]);
      sg  <= sg + SUM_W'(rd_data[15:8]);
      sb  <= sb + SUM_W'(rd_data[7:0]);
      cnt <= cnt + CNT_W'(1);
    end
  end

  // Operand selection for the shared divider.
  always_comb begin
    div_num = '0;
    div_den = DIV_W'(1);
    case (cmd.div_sel)
      DIV_COLS: begin
        div_num = DIV_W'(w_eff);
        div_den = DIV_W'(b_eff);
      end
      DIV_ROWS: begin
        div_num = DIV_W'(h_eff);
        div_den = DIV_W'(b_eff);
      end
      DIV_RED: begin
        div_num = DIV_W'(sr);
        div_den = DIV_W'(cnt);
      end
      DIV_GREEN: begin
        div_num = DIV_W'(sg);
        div_den = DIV_W'(cnt);
      end
      DIV_BLUE: begin
        div_num = DIV_W'(sb);
        div_den = DIV_W'(cnt);
      end
      DIV_IDX: begin
        div_num = (avg > lmin) ? DIV_W'(avg - lmin) * DIV_W'(g_eff - GW'(1)) : '0;
        div_den = (lmax > lmin) ? DIV_W'(lmax - lmin) : DIV_W'(1);
      end
      default: begin
        div_num = '0;
        div_den = DIV_W'(1);
      end
    endcase
  end

  blgq_div #(
    .W(DIV_W)
  ) u_div (
    .clk  (clk),
    .rst  (rst),
    .start(cmd.div_start),
    .num  (div_num),
    .den  (div_den),
    .done (div_done),
    .quo  (div_quo)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      cols <= '0;
      rows <= '0;
    end else if (div_done) begin
      case (cmd.div_sel)
        DIV_COLS: cols <= XW'(div_quo);
        DIV_ROWS: rows <= YW'(div_quo);
        default: ;
      endcase
    end
  end

  // The mean of the three channel means is taken by a reciprocal multiply.
  assign avg_sum  = 10'(mr) + 10'(mg) + 10'(mb);
  assign avg_prod = 20'(avg_sum) * 20'(AVG_RECIP);

  // In grey mode the red mean stands for all three channels.
  always_ff @(posedge clk) begin
    if (cmd.average) begin
      avg <= avg_prod[AVG_SHIFT+7:AVG_SHIFT];
    end
    if (div_done) begin
      case (cmd.div_sel)
        DIV_RED: begin
          mr <= div_quo[7:0];
          if (!colour_mode) begin
            mg <= div_quo[7:0];
            mb <= div_quo[7:0];
          end
        end
        DIV_GREEN: mg <= div_quo[7:0];
        DIV_BLUE:  mb <= div_quo[7:0];
        DIV_IDX:   idx_raw <= div_quo[15:0];
        default: ;
      endcase
    end
  end

  assign gm1       = g_eff - GW'(1);
  assign glyph     = (idx_raw > 16'(gm1)) ? gm1 : GW'(idx_raw);
  assign glyph_sel = invert_order ? gm1 - glyph : glyph;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.finish && out_free) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.finish && out_free) begin
      if (empty) begin
        out_item <= '0;
      end else begin
        out_item.glyph_index <= 6'(glyph_sel);
        out_item.mean_red    <= mr;
        out_item.mean_green  <= mg;
        out_item.mean_blue   <= mb;
        out_item.cell_column <= 9'(col);
        out_item.cell_row    <= 8'(row);
        out_item.last_cell   <= (col == cols - XW'(1)) && (row == rows - YW'(1));
        out_item.cell_valid  <= 1'b1;
      end
    end
  end

  assign status.empty_grid  = empty;
  assign status.scan_last   = scan_last;
  assign status.div_done    = div_done;
  assign status.out_free    = out_free;
  assign status.colour_mode = colour_mode;

  `ASSERT_NEXT(a_luma_bounds, clk, rst, cmd.load, lmin <= lmax, "luma bounds crossed after a load")
  `ASSERT_SYNC(a_scan_in_frame, clk, rst, !cmd.scan || (WAW'(rd_addr) < frame_pixels), "window read outside the frame")
  `ASSERT_SYNC(a_cursor_in_grid, clk, rst, !(cmd.finish && out_free && !empty) || (col < cols && row < rows), "cell cursor outside the grid")

endmodule

// ===== hdl/block_luma_glyph_quantizer.sv =====
// ----------------------------------------------------------------------------
// block_luma_glyph_quantizer
// Loads an RGB frame into a pixel store and classifies block-pitched cells
// by mean colour and a brightness glyph index.
// ----------------------------------------------------------------------------
// Items enter on the in channel (valid/ready). A load item (cmd 0) stores
// one pixel in raster order and updates the frame's luma bounds, unless the
// frame is full; it yields no result. A cell item (cmd 1) yields exactly one
// result on the out channel for the next cell of the grid in raster order.
// Set frame_start on the first item of a frame.
// A cell reads each pixel of its clipped window, one per cycle, from the
// single read port of the store, and runs its divisions on the one shared
// bit-serial divider: four in grey mode, six in colour mode.
// One item is worked on at a time. The result sits in an output register, so
// the next item is taken while it waits; a stalled receiver only holds back
// the following cell item at its final step.
// Registers are written through the cfg channel, always ready; the user must
// write them only while the block is idle, as the block does not enforce it.
// Reset restores register defaults, clears the luma bounds, the write address
// and the cell cursor; the pixel store is not cleared.
// ----------------------------------------------------------------------------
module block_luma_glyph_quantizer #(
  parameter int MAX_WIDTH  = 320,
  parameter int MAX_HEIGHT = 240,
  parameter int MAX_BLOCK  = 32,
  parameter int MAX_GLYPHS = 64
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             in_valid,
  output logic                             in_ready,
  input  blgq_pkg::in_item_t               in_item,
  output logic                             out_valid,
  input  logic                             out_ready,
  output blgq_pkg::out_item_t              out_item,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic [blgq_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [blgq_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import blgq_pkg::*;

  ctrl_cmd_t    cmd;
  ctrl_status_t status;

  assign cfg_ready = 1'b1;

  blgq_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(in_valid),
    .in_cmd  (in_item.cmd),
    .in_ready(in_ready),
    .cmd     (cmd),
    .status  (status)
  );

  blgq_dp #(
    .MAX_WIDTH (MAX_WIDTH),
    .MAX_HEIGHT(MAX_HEIGHT),
    .MAX_BLOCK (MAX_BLOCK),
    .MAX_GLYPHS(MAX_GLYPHS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .in_accept(in_valid && in_ready),
    .in_item  (in_item),
    .cfg_write(cfg_valid && cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .out_ready(out_ready),
    .out_valid(out_valid),
    .out_item (out_item),
    .cmd      (cmd),
    .status   (status)
  );

endmodule

// ===== verif/blgq_checker.sv =====
// ----------------------------------------------------------------------------
// blgq_checker
// Watches the in, out and cfg channels of the luma glyph quantizer, keeps
// its own copy of the pixel store, luma bounds and cell cursor, works out
// each cell result and compares the results in order, field by field.
// ----------------------------------------------------------------------------
module blgq_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            in_valid,
  input  logic                            in_ready,
  input  blgq_pkg::in_item_t              in_item,
  input  logic                            out_valid,
  input  logic                            out_ready,
  input  blgq_pkg::out_item_t             out_item,
  input  logic                            cfg_valid,
  input  logic                            cfg_ready,
  input  logic [blgq_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [blgq_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                              errors,
  output int                              pending,
  output int                              cells_checked
);
  import blgq_pkg::*;

  localparam int STORE_WORDS = 320 * 240;

  bit [23:0] frame_mem [0:STORE_WORDS-1];
  int        lo_luma, hi_luma, wr_addr, col_pos, row_pos;
  int        blk_reg, glyph_reg, inv_reg, colour_reg, wid_reg, hgt_reg;
  out_item_t cell_q[$];

  function automatic int clip(int v, int lo, int hi);
    return (v < lo) ? lo : ((v > hi) ? hi : v);
  endfunction

  function automatic int luma(int r, int g, int b);
    int l;
    l = (13933 * r + 46871 * g + 7471 * b) >>> 16;
    return (l > 255) ? 255 : l;
  endfunction

  // Carries out one accepted item; returns 1 with the cell in res for a cell item.
  function automatic bit apply_item(in_item_t it, output out_item_t res);
    int w, h, b, g, cols, rows, x0, y0, sr, sg, sb, cnt, l, mr, mg, mb, avg, rng, diff, idx;
    w = clip(wid_reg, 1, 320);
    h = clip(hgt_reg, 1, 240);
    b = clip(blk_reg, 1, 32);
    g = clip(glyph_reg, 1, 64);
    cols = w / b;
    rows = h / b;
    res = '0;
    if (it.frame_start) begin
      wr_addr = 0; lo_luma = 255; hi_luma = 0; col_pos = 0; row_pos = 0;
    end
    if (it.cmd == CMD_LOAD) begin
      l = luma(it.pixel_red, it.pixel_green, it.pixel_blue);
      if (wr_addr < w * h) begin
        frame_mem[wr_addr] = colour_reg ? {it.pixel_red, it.pixel_green, it.pixel_blue}
                                        : {l[7:0], l[7:0], l[7:0]};
        if (l < lo_luma) lo_luma = l;
        if (l > hi_luma) hi_luma = l;
        wr_addr++;
      end
      return 0;
    end
    if (cols == 0 || rows == 0) return 1;
    if (col_pos >= cols) col_pos = 0;
    if (row_pos >= rows) row_pos = 0;
    x0 = col_pos * b;
    y0 = row_pos * b;
    sr = 0; sg = 0; sb = 0; cnt = 0;
    for (int j = y0 - b; j < y0 + b; j++) begin
      if (j < 0 || j >= h) continue;
      for (int i = x0 - b; i < x0 + b; i++) begin
        if (i < 0 || i >= w) continue;
        sr += frame_mem[j * w + i][23:16];
        sg += frame_mem[j * w + i][15:8];
        sb += frame_mem[j * w + i][7:0];
        cnt++;
      end
    end
    if (cnt == 0) cnt = 1;
    mr = sr / cnt;
    mg = colour_reg ? sg / cnt : mr;
    mb = colour_reg ? sb / cnt : mr;
    avg = (mr + mg + mb) / 3;
    rng = (hi_luma > lo_luma) ? hi_luma - lo_luma : 1;
    diff = avg - lo_luma;
    idx = (diff <= 0) ? 0 : (diff * (g - 1)) / rng;
    if (idx > g - 1) idx = g - 1;
    if (inv_reg) idx = (g - 1) - idx;
    res.glyph_index = idx[5:0];
    res.mean_red    = mr[7:0];
    res.mean_green  = mg[7:0];
    res.mean_blue   = mb[7:0];
    res.cell_column = col_pos[8:0];
    res.cell_row    = row_pos[7:0];
    res.last_cell   = (col_pos == cols - 1) && (row_pos == rows - 1);
    res.cell_valid  = 1'b1;
    col_pos++;
    if (col_pos >= cols) begin
      col_pos = 0;
      row_pos++;
      if (row_pos >= rows) row_pos = 0;
    end
    return 1;
  endfunction

  task automatic compare_field(string name, int want, int got);
    if (want != got) begin
      $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, name, want, got);
      errors++;
    end
  endtask

  always @(posedge clk) begin
    out_item_t res, want;
    if (rst) begin
      lo_luma = 255; hi_luma = 0; wr_addr = 0; col_pos = 0; row_pos = 0;
      blk_reg = RST_BLOCK_SIZE; glyph_reg = RST_GLYPH_COUNT; inv_reg = RST_INVERT_ORDER;
      colour_reg = RST_COLOUR_MODE; wid_reg = RST_IMAGE_WIDTH; hgt_reg = RST_IMAGE_HEIGHT;
      cell_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_reg_t'(cfg_index))
          REG_BLOCK_SIZE:   blk_reg    = cfg_data[5:0];
          REG_GLYPH_COUNT:  glyph_reg  = cfg_data[6:0];
          REG_INVERT_ORDER: inv_reg    = cfg_data[0];
          REG_COLOUR_MODE:  colour_reg = cfg_data[0];
          REG_IMAGE_WIDTH:  wid_reg    = cfg_data[8:0];
          REG_IMAGE_HEIGHT: hgt_reg    = cfg_data[7:0];
          default: ;
        endcase
      end
      if (in_valid && in_ready) begin
        if (apply_item(in_item, res)) cell_q.push_back(res);
      end
      if (out_valid && out_ready) begin
        if (cell_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, actual %h", $time, out_item);
          errors++;
        end else begin
          want = cell_q.pop_front();
          compare_field("glyph_index", want.glyph_index, out_item.glyph_index);
          compare_field("mean_red", want.mean_red, out_item.mean_red);
          compare_field("mean_green", want.mean_green, out_item.mean_green);
          compare_field("mean_blue", want.mean_blue, out_item.mean_blue);
          compare_field("cell_column", want.cell_column, out_item.cell_column);
          compare_field("cell_row", want.cell_row, out_item.cell_row);
          compare_field("last_cell", want.last_cell, out_item.last_cell);
          compare_field("cell_valid", want.cell_valid, out_item.cell_valid);
          cells_checked++;
        end
      end
    end
    pending = cell_q.size();
  end

endmodule

// ===== verif/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Drives frames of pixels and cell requests into the luma glyph quantizer
// under a range of register settings, with random idling on both sides, and
// gives the verdict from the checker's mismatch count and pending results.
// ----------------------------------------------------------------------------
module tb_top;
  import blgq_pkg::*;

  logic                  clk, rst;
  logic                  in_valid, in_ready, out_valid, out_ready, cfg_valid, cfg_ready;
  in_item_t              in_item;
  out_item_t             out_item;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors, pending, cells_checked;

  int  items_sent, loads_sent, cells_sent, settings_run;
  int  cur_blk, cur_glyph, cur_wid, cur_hgt, addr_copy, filled;
  bit  quiet, stall_req;

  block_luma_glyph_quantizer dut (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data
  );

  blgq_checker u_checker (
    .clk, .rst, .in_valid, .in_ready, .in_item, .out_valid, .out_ready, .out_item,
    .cfg_valid, .cfg_ready, .cfg_index, .cfg_data, .errors, .pending, .cells_checked
  );

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  initial begin
    #(8 * 4000000);
    $display("FAIL");
    $finish;
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (quiet || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  function automatic logic [7:0] pick_level();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return 8'd0;
    if (r == 1) return 8'd255;
    return 8'($urandom_range(0, 255));
  endfunction

  function automatic int eff_w();
    return (cur_wid < 1) ? 1 : ((cur_wid > 320) ? 320 : cur_wid);
  endfunction

  function automatic int eff_h();
    return (cur_hgt < 1) ? 1 : ((cur_hgt > 240) ? 240 : cur_hgt);
  endfunction

  function automatic int eff_b();
    return (cur_blk < 1) ? 1 : ((cur_blk > 32) ? 32 : cur_blk);
  endfunction

  function automatic bit grid_empty();
    return (eff_w() / eff_b() == 0) || (eff_h() / eff_b() == 0);
  endfunction

  // Receiver: random stalls, and one long hold-off on request.
  initial begin
    int gap;
    out_ready = 1'b0;
    @(posedge clk);
    forever begin
      if (stall_req) begin
        out_ready <= 1'b0;
        repeat (3000) @(posedge clk);
        stall_req = 1'b0;
      end else begin
        gap = pick_gap();
        if (gap > 0) begin
          out_ready <= 1'b0;
          repeat (gap) @(posedge clk);
        end
        out_ready <= 1'b1;
        @(posedge clk);
      end
    end
  end

  task automatic send_item(logic op, logic fs, logic [7:0] r, logic [7:0] g, logic [7:0] b);
    in_item_t it;
    int gap;
    it.cmd = op; it.frame_start = fs;
    it.pixel_red = r; it.pixel_green = g; it.pixel_blue = b;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (!in_ready);
    items_sent++;
    if (fs) addr_copy = 0;
    if (op == CMD_LOAD) begin
      loads_sent++;
      if (addr_copy < eff_w() * eff_h()) addr_copy++;
      if (addr_copy > filled) filled = addr_copy;
    end else begin
      cells_sent++;
    end
  endtask

  // Valid drops at the accepting edge and the task returns only at the following
  // edge, so back-to-back writes never drive cfg_valid twice in one step.
  task automatic write_reg(cfg_reg_t idx, int val);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= CFG_DATA_W'(val);
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    case (idx)
      REG_BLOCK_SIZE:   cur_blk   = val;
      REG_GLYPH_COUNT:  cur_glyph = val;
      REG_IMAGE_WIDTH:  cur_wid   = val;
      REG_IMAGE_HEIGHT: cur_hgt   = val;
      default: ;
    endcase
    @(posedge clk);
  endtask

  // Registers change only once the block has gone quiet; a load can still be
  // in flight after the last result, so the task keeps waiting after that.
  task automatic settle();
    in_valid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (8) @(posedge clk);
  endtask

  task automatic configure(int bs, int gc, int inv, int cm, int w, int h);
    settle();
    write_reg(REG_BLOCK_SIZE, bs);
    write_reg(REG_GLYPH_COUNT, gc);
    write_reg(REG_INVERT_ORDER, inv);
    write_reg(REG_COLOUR_MODE, cm);
    write_reg(REG_IMAGE_WIDTH, w);
    write_reg(REG_IMAGE_HEIGHT, h);
    settings_run++;
  endtask

  task automatic load_frame();
    for (int i = 0; i < eff_w() * eff_h(); i++)
      send_item(CMD_LOAD, i == 0, pick_level(), pick_level(), pick_level());
  endtask

  task automatic ask_cells(int n);
    for (int i = 0; i < n; i++)
      send_item(CMD_CELL, 1'b0, pick_level(), pick_level(), pick_level());
  endtask

  initial begin
    int n, noise;
    rst = 1'b1;
    in_valid = 1'b0; in_item = '0;
    cfg_valid = 1'b0; cfg_index = '0; cfg_data = '0;
    quiet = 1'b0; stall_req = 1'b0;
    items_sent = 0; loads_sent = 0; cells_sent = 0; settings_run = 0;
    addr_copy = 0; filled = 0;
    cur_blk = RST_BLOCK_SIZE; cur_glyph = RST_GLYPH_COUNT;
    cur_wid = RST_IMAGE_WIDTH; cur_hgt = RST_IMAGE_HEIGHT;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: black, white (luma saturates), primaries, then a grid wrap.
    configure(2, 10, 0, 0, 4, 4);
    send_item(CMD_LOAD, 1'b1, 8'd0, 8'd0, 8'd0);
    send_item(CMD_LOAD, 1'b0, 8'd255, 8'd255, 8'd255);
    send_item(CMD_LOAD, 1'b0, 8'd255, 8'd0, 8'd0);
    send_item(CMD_LOAD, 1'b0, 8'd0, 8'd255, 8'd0);
    send_item(CMD_LOAD, 1'b0, 8'd0, 8'd0, 8'd255);
    for (int i = 5; i < 16; i++) send_item(CMD_LOAD, 1'b0, pick_level(), 8'd128, pick_level());
    ask_cells(5);
    // Single-glyph, inverted, zero and oversized glyph counts.
    settle(); write_reg(REG_GLYPH_COUNT, 1); write_reg(REG_INVERT_ORDER, 1); ask_cells(1);
    settle(); write_reg(REG_GLYPH_COUNT, 0); ask_cells(1);
    settle(); write_reg(REG_GLYPH_COUNT, 127); ask_cells(1);

    // Colour frame; then a larger pitch leaves the cursor outside the grid.
    quiet = 1'b1;
    configure(1, 64, 0, 1, 8, 8);
    load_frame();
    send_item(CMD_LOAD, 1'b0, 8'd1, 8'd2, 8'd3);
    ask_cells(10);
    settle(); write_reg(REG_BLOCK_SIZE, 4); ask_cells(3);
    // A restarting cell request leaves the mean below the fresh minimum.
    send_item(CMD_CELL, 1'b1, 8'd0, 8'd0, 8'd0);
    quiet = 1'b0;
    // An empty grid, then a one-column grid, with zero and oversized registers.
    configure(63, 64, 1, 0, 511, 0);
    ask_cells(2);
    configure(0, 2, 0, 0, 0, 5);
    ask_cells(2);

    // Random settings; one of them also holds the receiver off for a while.
    while (items_sent < 750) begin
      n = $urandom_range(0, 9);
      quiet = ($urandom_range(0, 4) == 0);
      configure((n == 0) ? $urandom_range(0, 40) : $urandom_range(1, 5),
                ($urandom_range(0, 5) == 0) ? $urandom_range(0, 127) : $urandom_range(2, 64),
                $urandom_range(0, 1), $urandom_range(0, 1),
                $urandom_range(0, 16), $urandom_range(0, 12));
      if (filled < eff_w() * eff_h() || $urandom_range(0, 3) != 0) load_frame();
      if (grid_empty()) n = $urandom_range(1, 3);
      else n = (eff_w() / eff_b()) * (eff_h() / eff_b()) + $urandom_range(0, 4);
      if (n > 40) n = 40;
      if (settings_run == 8) begin
        stall_req = 1'b1;
        n = n + 6;
      end
      for (int i = 0; i < n; i++) begin
        noise = $urandom_range(0, 19);
        if (noise == 0) send_item(CMD_LOAD, 1'b0, pick_level(), pick_level(), pick_level());
        else if (noise == 1) send_item(CMD_CELL, 1'b1, pick_level(), 8'd0, pick_level());
        else ask_cells(1);
      end
    end

    // The widest pitch over a frame that just holds one cell.
    quiet = 1'b1;
    configure(32, 64, 1, 1, 32, 32);
    load_frame();
    ask_cells(3);

    settle();
    repeat (40) @(posedge clk);
    $display("Ran %0d items (%0d loads, %0d cell requests) over %0d register settings.",
             items_sent, loads_sent, cells_sent, settings_run);
    $display("Checked %0d cell results; %0d mismatches.", cells_checked, errors);
    if (errors == 0 && pending == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end

endmodule

// ===== sim.f =====
+incdir+hdl
hdl/blgq_pkg.sv
hdl/blgq_ram.sv
hdl/blgq_div.sv
hdl/blgq_ctrl.sv
hdl/blgq_dp.sv
hdl/block_luma_glyph_quantizer.sv
verif/blgq_checker.sv
verif/tb_top.sv
